// ===== rtl/core/bsn_pkg.sv =====
// shared types and constants for the bond separation neighbor set block
`default_nettype none
package bsn_pkg;

  localparam int ATOM_W     = 10;
  localparam int CNT_W      = 4;
  localparam int SIZE_W     = 8;
  localparam int MARK_W     = 3;
  localparam int MARK_DEPTH = 1 << ATOM_W;
  localparam int MARK_AW    = ATOM_W;

  // request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FULL = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

  // per-atom mark codes used while a query walks
  localparam logic [MARK_W-1:0] MK_NONE = 3'd0;
  localparam logic [MARK_W-1:0] MK_OWN  = 3'd1;
  localparam logic [MARK_W-1:0] MK_L0   = 3'd2;

  typedef struct packed {
    logic [ATOM_W-1:0] cnt_rd_atom;
    logic              cnt_we;
    logic [ATOM_W-1:0] cnt_wr_atom;
    logic [CNT_W-1:0]  cnt_wr_val;
    logic [ATOM_W-1:0] tbl_rd_atom;
    logic [CNT_W-1:0]  tbl_rd_k;
    logic              tbl_we;
    logic [ATOM_W-1:0] tbl_wr_atom;
    logic [CNT_W-1:0]  tbl_wr_k;
    logic [ATOM_W-1:0] tbl_wr_val;
  } store_req_t;

endpackage
`default_nettype wire

// ===== rtl/core/bsn_nbr_store.sv =====
// neighbor count and neighbor list memories
`default_nettype none
module bsn_nbr_store import bsn_pkg::*; #(
  parameter int MAX_ATOMS   = 1024,
  parameter int MAX_VALENCE = 8
) (
  input  wire logic              clk_i,
  input  wire store_req_t        req_i,
  output logic [CNT_W-1:0]       cnt_o,
  output logic [ATOM_W-1:0]      tbl_o
);

  localparam int AW  = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int TD  = MAX_ATOMS * MAX_VALENCE;
  localparam int TAW = (TD > 1) ? $clog2(TD) : 1;

  logic [CNT_W-1:0]  cnt_mem [MAX_ATOMS];
  logic [ATOM_W-1:0] tbl_mem [TD];
  logic [CNT_W-1:0]  cnt_rd_q;
  logic              rng_q;

  logic rd_rng, cwr_rng, twr_rng;
  logic [TAW-1:0] trd_addr, twr_addr;

  assign rd_rng  = 32'(req_i.cnt_rd_atom) < MAX_ATOMS;
  assign cwr_rng = 32'(req_i.cnt_wr_atom) < MAX_ATOMS;
  assign twr_rng = 32'(req_i.tbl_wr_atom) < MAX_ATOMS;
  assign trd_addr = TAW'(32'(req_i.tbl_rd_atom) * MAX_VALENCE + 32'(req_i.tbl_rd_k));
  assign twr_addr = TAW'(32'(req_i.tbl_wr_atom) * MAX_VALENCE + 32'(req_i.tbl_wr_k));

  always_ff @(posedge clk_i) begin
    if (req_i.cnt_we && cwr_rng) begin
      cnt_mem[AW'(req_i.cnt_wr_atom)] <= req_i.cnt_wr_val;
    end
    cnt_rd_q <= cnt_mem[AW'(req_i.cnt_rd_atom)];
    rng_q    <= rd_rng;
  end

  always_ff @(posedge clk_i) begin
    if (req_i.tbl_we && twr_rng) begin
      tbl_mem[twr_addr] <= req_i.tbl_wr_val;
    end
    tbl_o <= tbl_mem[trd_addr];
  end

  // out-of-range atoms have no neighbors, count clamps to valence
  always_comb begin
    if (!rng_q) begin
      cnt_o = '0;
    end else if (32'(cnt_rd_q) > MAX_VALENCE) begin
      cnt_o = CNT_W'(MAX_VALENCE);
    end else begin
      cnt_o = cnt_rd_q;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bond_separation_neighbor_sets.sv =====
// top level of the bond separation neighbor set block
`default_nettype none
// Keeps a bonded-neighbor table and answers 1-3, 1-4 and 1-5 set queries.
// An item is taken when start_i is high and busy_o low; one result beat
// per item appears with done_o for a single cycle and cannot be held off.
// After reset and after every clear item the block runs a clearing pass
// over the count memory and the per-atom mark memory with busy_o high.
// A query marks its own neighbors, then visits each source atom in turn:
// the walk does one neighbor-table read and one read-modify-write of the
// mark memory per candidate, and the final scan of the 1024-entry mark
// memory both picks the member at the requested slot in ascending order
// and clears the marks for the next query.
module bond_separation_neighbor_sets import bsn_pkg::*; #(
  parameter int MAX_ATOMS   = 1024,
  parameter int MAX_VALENCE = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [ATOM_W-1:0] atom_i,
  input  wire logic [ATOM_W-1:0] partner_i,
  input  wire logic [2:0]        bonds_apart_i,
  input  wire logic [SIZE_W-1:0] slot_i,
  output logic                   done_o,
  output logic [SIZE_W-1:0]      set_size_o,
  output logic [ATOM_W-1:0]      member_o,
  output logic                   slot_valid_o,
  output logic [1:0]             status_o
);

  localparam int LIM0      = 3 * MAX_VALENCE;
  localparam int LIM1      = 9 * MAX_VALENCE;
  localparam int LIM2      = 27 * MAX_VALENCE;
  localparam int LST_DEPTH = 12 * MAX_VALENCE;
  localparam int LW        = $clog2(LST_DEPTH);
  localparam int SCW       = MARK_AW + 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SWEEP = 4'd1;
  localparam logic [3:0] ST_AP_WR = 4'd2;
  localparam logic [3:0] ST_Q_CNT = 4'd3;
  localparam logic [3:0] ST_OWN   = 4'd4;
  localparam logic [3:0] ST_OWN_W = 4'd5;
  localparam logic [3:0] ST_SRC   = 4'd6;
  localparam logic [3:0] ST_SRC_W = 4'd7;
  localparam logic [3:0] ST_CNT_W = 4'd8;
  localparam logic [3:0] ST_NB    = 4'd9;
  localparam logic [3:0] ST_NB_W  = 4'd10;
  localparam logic [3:0] ST_MK    = 4'd11;
  localparam logic [3:0] ST_SCAN  = 4'd12;

  logic [3:0] state_q, state_d;
  logic       boot_q, boot_d;

  // latched item
  logic [ATOM_W-1:0] atom_q, atom_d;
  logic [ATOM_W-1:0] partner_q, partner_d;
  logic [1:0]        top_q, top_d;
  logic [SIZE_W-1:0] slot_q, slot_d;

  // walk registers
  logic [MARK_AW-1:0] sw_q, sw_d;
  logic [SCW-1:0]     sc_q, sc_d;
  logic [1:0]         cur_q, cur_d;
  logic [CNT_W-1:0]   own_n_q, own_n_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CNT_W-1:0]   k_q, k_d;
  logic [SIZE_W-1:0]  j_q, j_d;
  logic [SIZE_W-1:0]  src_n_q, src_n_d;
  logic [SIZE_W-1:0]  rc_q, rc_d;
  logic [SIZE_W-1:0]  ucnt_q, ucnt_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [SIZE_W-1:0]  seen_q, seen_d;
  logic [ATOM_W-1:0]  jj_q, jj_d;
  logic [ATOM_W-1:0]  kk_q, kk_d;
  logic [ATOM_W-1:0]  hit_q, hit_d;
  logic               found_q, found_d;
  logic               ovf_q, ovf_d;

  // result beat
  logic              done_q, done_d;
  logic [SIZE_W-1:0] res_size_q, res_size_d;
  logic [ATOM_W-1:0] res_mem_q, res_mem_d;
  logic              res_val_q, res_val_d;
  logic [1:0]        res_stat_q, res_stat_d;

  // memories
  store_req_t        sreq;
  logic [CNT_W-1:0]  s_cnt;
  logic [ATOM_W-1:0] s_tbl;

  logic [MARK_W-1:0]  mark_mem [MARK_DEPTH];
  logic [MARK_W-1:0]  mark_rd_q;
  logic [MARK_AW-1:0] mark_ra, mark_wa;
  logic [MARK_W-1:0]  mark_wd;
  logic               mark_we;

  logic [ATOM_W-1:0] lst_mem [LST_DEPTH];
  logic [ATOM_W-1:0] lst_rd_q;
  logic [LW-1:0]     lst_ra, lst_wa;
  logic              lst_we;

  logic              accept;
  logic [SIZE_W-1:0] lim;
  logic [MARK_W-1:0] cur_code;
  logic              excl;
  logic              atom_rng;
  logic [ATOM_W-1:0] src_atom;

  bsn_nbr_store #(
    .MAX_ATOMS  (MAX_ATOMS),
    .MAX_VALENCE(MAX_VALENCE)
  ) u_store (
    .clk_i(clk_i),
    .req_i(sreq),
    .cnt_o(s_cnt),
    .tbl_o(s_tbl)
  );

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    mark_rd_q <= mark_mem[mark_ra];
  end

  always_ff @(posedge clk_i) begin
    if (lst_we) begin
      lst_mem[lst_wa] <= kk_q;
    end
    lst_rd_q <= lst_mem[lst_ra];
  end

  assign accept   = start_i && (state_q == ST_IDLE);
  assign atom_rng = 32'(atom_q) < MAX_ATOMS;
  assign cur_code = MK_L0 + MARK_W'(cur_q);
  assign src_atom = (cur_q == 2'd0) ? s_tbl : lst_rd_q;
  // a candidate is dropped when it is the atom itself or sits in a nearer set
  assign excl = (kk_q == atom_q) || ((mark_rd_q != MK_NONE) && (mark_rd_q < cur_code));

  always_comb begin
    unique case (cur_q)
      2'd0:    lim = SIZE_W'(LIM0);
      2'd1:    lim = SIZE_W'(LIM1);
      default: lim = SIZE_W'(LIM2);
    endcase
  end

  always_comb begin
    state_d    = state_q;
    boot_d     = boot_q;
    atom_d     = atom_q;
    partner_d  = partner_q;
    top_d      = top_q;
    slot_d     = slot_q;
    sw_d       = sw_q;
    sc_d       = sc_q;
    cur_d      = cur_q;
    own_n_d    = own_n_q;
    cnt_d      = cnt_q;
    k_d        = k_q;
    j_d        = j_q;
    src_n_d    = src_n_q;
    rc_d       = rc_q;
    ucnt_d     = ucnt_q;
    size_d     = size_q;
    seen_d     = seen_q;
    jj_d       = jj_q;
    kk_d       = kk_q;
    hit_d      = hit_q;
    found_d    = found_q;
    ovf_d      = ovf_q;
    done_d     = 1'b0;
    res_size_d = res_size_q;
    res_mem_d  = res_mem_q;
    res_val_d  = res_val_q;
    res_stat_d = res_stat_q;

    sreq             = '0;
    sreq.cnt_rd_atom = atom_q;
    sreq.tbl_rd_atom = atom_q;
    sreq.tbl_rd_k    = k_q;
    mark_ra = kk_q;
    mark_we = 1'b0;
    mark_wa = kk_q;
    mark_wd = MK_NONE;
    lst_we  = 1'b0;
    lst_ra  = LW'(j_q);
    lst_wa  = (cur_q == 2'd1) ? LW'(LIM0 + 32'(ucnt_q)) : LW'(ucnt_q);

    unique case (state_q)
      ST_IDLE: begin
        sreq.cnt_rd_atom = atom_i;
        if (accept) begin
          atom_d    = atom_i;
          partner_d = partner_i;
          slot_d    = slot_i;
          if (bonds_apart_i < 3'd2) begin
            top_d = 2'd0;
          end else if (bonds_apart_i > 3'd4) begin
            top_d = 2'd2;
          end else begin
            top_d = 2'(bonds_apart_i - 3'd2);
          end
          res_size_d = '0;
          res_mem_d  = '0;
          res_val_d  = 1'b0;
          res_stat_d = STAT_OK;
          unique case (req_type_i)
            REQ_CLEAR: begin
              sw_d    = '0;
              state_d = ST_SWEEP;
            end
            REQ_APPEND: state_d = ST_AP_WR;
            REQ_QUERY:  state_d = ST_Q_CNT;
            default:    done_d  = 1'b1;
          endcase
        end
      end

      // zero the counts and the marks, one entry a cycle
      ST_SWEEP: begin
        sreq.cnt_we      = 1'b1;
        sreq.cnt_wr_atom = sw_q;
        mark_we          = 1'b1;
        mark_wa          = sw_q;
        sw_d             = sw_q + 1'b1;
        if (sw_q == MARK_AW'(MARK_DEPTH - 1)) begin
          boot_d  = 1'b0;
          done_d  = !boot_q;
          state_d = ST_IDLE;
        end
      end

      ST_AP_WR: begin
        if (atom_rng) begin
          if (32'(s_cnt) >= MAX_VALENCE) begin
            res_stat_d = STAT_FULL;
          end else begin
            sreq.tbl_we      = 1'b1;
            sreq.tbl_wr_atom = atom_q;
            sreq.tbl_wr_k    = s_cnt;
            sreq.tbl_wr_val  = partner_q;
            sreq.cnt_we      = 1'b1;
            sreq.cnt_wr_atom = atom_q;
            sreq.cnt_wr_val  = s_cnt + 1'b1;
          end
        end
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      ST_Q_CNT: begin
        own_n_d = s_cnt;
        k_d     = '0;
        ovf_d   = 1'b0;
        state_d = ST_OWN;
      end

      // mark the bonded partners of the queried atom
      ST_OWN: begin
        if (k_q < own_n_q) begin
          state_d = ST_OWN_W;
        end else begin
          cur_d   = 2'd0;
          src_n_d = SIZE_W'(own_n_q);
          j_d     = '0;
          rc_d    = '0;
          ucnt_d  = '0;
          state_d = ST_SRC;
        end
      end

      ST_OWN_W: begin
        mark_we = 1'b1;
        mark_wa = s_tbl;
        mark_wd = MK_OWN;
        k_d     = k_q + 1'b1;
        state_d = ST_OWN;
      end

      // next member of the nearer set
      ST_SRC: begin
        sreq.tbl_rd_k = CNT_W'(j_q);
        lst_ra = (cur_q == 2'd2) ? LW'(LIM0 + 32'(j_q)) : LW'(j_q);
        if (j_q < src_n_q) begin
          state_d = ST_SRC_W;
        end else if (cur_q == top_q) begin
          size_d  = ucnt_q;
          sc_d    = '0;
          seen_d  = '0;
          found_d = 1'b0;
          state_d = ST_SCAN;
        end else begin
          src_n_d = ucnt_q;
          cur_d   = cur_q + 1'b1;
          j_d     = '0;
          rc_d    = '0;
          ucnt_d  = '0;
        end
      end

      ST_SRC_W: begin
        jj_d             = src_atom;
        sreq.cnt_rd_atom = src_atom;
        state_d          = ST_CNT_W;
      end

      ST_CNT_W: begin
        cnt_d   = s_cnt;
        k_d     = '0;
        state_d = ST_NB;
      end

      ST_NB: begin
        sreq.tbl_rd_atom = jj_q;
        if (k_q < cnt_q) begin
          state_d = ST_NB_W;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_SRC;
        end
      end

      ST_NB_W: begin
        kk_d    = s_tbl;
        mark_ra = s_tbl;
        state_d = ST_MK;
      end

      // count the candidate, add it to this level once
      ST_MK: begin
        k_d     = k_q + 1'b1;
        state_d = ST_NB;
        if (!excl) begin
          if (rc_q == lim) begin
            ovf_d   = 1'b1;
            sc_d    = '0;
            seen_d  = '0;
            found_d = 1'b0;
            state_d = ST_SCAN;
          end else begin
            rc_d = rc_q + 1'b1;
            if (mark_rd_q != cur_code) begin
              mark_we = 1'b1;
              mark_wd = cur_code;
              lst_we  = (cur_q != 2'd2);
              ucnt_d  = ucnt_q + 1'b1;
            end
          end
        end
      end

      // ascending scan of the marks: picks the slot and clears behind itself
      ST_SCAN: begin
        mark_ra = sc_q[MARK_AW-1:0];
        sc_d    = sc_q + 1'b1;
        if (sc_q != '0) begin
          mark_we = 1'b1;
          mark_wa = MARK_AW'(sc_q - 1'b1);
          if (!ovf_q && (mark_rd_q == cur_code)) begin
            if (seen_q == slot_q) begin
              found_d = 1'b1;
              hit_d   = ATOM_W'(sc_q - 1'b1);
            end
            seen_d = seen_q + 1'b1;
          end
        end
        if (sc_q == SCW'(MARK_DEPTH)) begin
          res_stat_d = ovf_q ? STAT_OVF : STAT_OK;
          res_size_d = ovf_q ? '0 : size_q;
          res_val_d  = found_d && !ovf_q;
          res_mem_d  = (found_d && !ovf_q) ? hit_d : '0;
          done_d     = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      boot_q  <= 1'b1;
      sw_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      boot_q  <= boot_d;
      sw_q    <= sw_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    atom_q     <= atom_d;
    partner_q  <= partner_d;
    top_q      <= top_d;
    slot_q     <= slot_d;
    sc_q       <= sc_d;
    cur_q      <= cur_d;
    own_n_q    <= own_n_d;
    cnt_q      <= cnt_d;
    k_q        <= k_d;
    j_q        <= j_d;
    src_n_q    <= src_n_d;
    rc_q       <= rc_d;
    ucnt_q     <= ucnt_d;
    size_q     <= size_d;
    seen_q     <= seen_d;
    jj_q       <= jj_d;
    kk_q       <= kk_d;
    hit_q      <= hit_d;
    found_q    <= found_d;
    ovf_q      <= ovf_d;
    res_size_q <= res_size_d;
    res_mem_q  <= res_mem_d;
    res_val_q  <= res_val_d;
    res_stat_q <= res_stat_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign set_size_o   = res_size_q;
  assign member_o     = res_mem_q;
  assign slot_valid_o = res_val_q;
  assign status_o     = res_stat_q;

  // a result beat always ends the item
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result beat while busy");

  // only a no-op item finishes in the accept cycle
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_type_i != REQ_NONE)) |=> busy_o)
    else $error("item accepted without work");

  // a valid slot only comes with a clean query result
  a_slot_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && slot_valid_o) |-> (status_o == STAT_OK) && (set_size_o != '0))
    else $error("slot valid on a failed query");

  // the unique count of a level never runs past its raw count
  a_ucnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MK) |-> (ucnt_q <= rc_q) && (rc_q <= lim))
    else $error("level count out of bounds");

endmodule
`default_nettype wire
